// File: src/ipt_pkg.sv
// Shared types and constants of the IR pointer tracker.
package ipt_pkg;

  // Field and state widths
  typedef logic        [9:0]  coord_t;   // camera coordinate, 0 means not seen
  typedef logic        [10:0] half_t;    // position in half pixels
  typedef logic        [10:0] mem_t;     // remembered dot coordinate
  typedef logic signed [10:0] spc_t;     // signed dot spacing
  typedef logic        [12:0] size_t;    // screen size register
  typedef logic        [12:0] pix_t;     // pointer output in screen pixels
  typedef logic        [23:0] prod_t;    // position times screen size
  typedef logic        [22:0] num_t;     // product halved, numerator of the divide
  typedef logic        [13:0] quo_t;     // quotient estimate
  typedef logic        [13:0] recip_t;   // reciprocal multiplier
  typedef logic        [9:0]  div_t;     // constant divisor

  // Pointer position handed from the tracker to the scaler
  typedef struct packed {
    half_t x;
    half_t y;
  } pos_t;

  // Result of the single-dot logic on one axis
  typedef struct packed {
    mem_t  first;
    mem_t  second;
    half_t pos;
  } axis_res_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_SCREEN_WIDTH  = 1'b0,
    CFG_SCREEN_HEIGHT = 1'b1
  } cfg_idx_t;

  localparam size_t SCREEN_WIDTH_RST  = 13'd1024;
  localparam size_t SCREEN_HEIGHT_RST = 13'd768;

  // Marker for a dot that went out of view
  localparam mem_t  FAR_DOT = 11'd2047;

  // Clamp limits in half pixels
  localparam half_t LIMIT_X = 11'd2046;
  localparam half_t LIMIT_Y = 11'd1534;

  // floor(n / D) = floor(n * RECIP >> RECIP_SHIFT) or one more, for n < 2**23
  localparam int     RECIP_SHIFT = 23;
  localparam div_t   DIV_X       = 10'd1023;
  localparam div_t   DIV_Y       = 10'd767;
  localparam recip_t RECIP_X     = 14'(((1 << RECIP_SHIFT)) / 1023);
  localparam recip_t RECIP_Y     = 14'(((1 << RECIP_SHIFT)) / 767);

  localparam pix_t   OUT_MAX     = 13'd8191;

endpackage

// File: src/ipt_track.sv
// Dot tracking: dot memory, spacing and held position, with the position register.
module ipt_track (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            track_on,
  input  ipt_pkg::coord_t dot0_x,
  input  ipt_pkg::coord_t dot0_y,
  input  ipt_pkg::coord_t dot1_x,
  input  ipt_pkg::coord_t dot1_y,
  output logic            pos_valid,
  input  logic            pos_stall,
  output ipt_pkg::pos_t   pos
);

  // Single-dot case on one axis: keep the nearer remembered dot, shift by half the spacing
  function automatic ipt_pkg::axis_res_t track_axis(
    input ipt_pkg::coord_t p,
    input ipt_pkg::mem_t   first,
    input ipt_pkg::mem_t   second,
    input ipt_pkg::spc_t   spc,
    input ipt_pkg::half_t  lim
  );
    logic signed [11:0] d1s;
    logic signed [11:0] d2s;
    logic        [11:0] d1;
    logic        [11:0] d2;
    logic signed [12:0] two_p;
    logic signed [12:0] sp;
    logic signed [12:0] h;
    ipt_pkg::axis_res_t r;
    d1s   = $signed({1'b0, first})  - $signed({2'b00, p});
    d2s   = $signed({1'b0, second}) - $signed({2'b00, p});
    d1    = d1s[11] ? 12'(-d1s) : 12'(d1s);
    d2    = d2s[11] ? 12'(-d2s) : 12'(d2s);
    two_p = $signed({2'b00, p, 1'b0});
    sp    = $signed({{2{spc[10]}}, spc});
    r.first  = first;
    r.second = second;
    if (d1 < d2) begin
      r.second = ipt_pkg::FAR_DOT;
      h        = two_p - sp;
    end else begin
      r.first = ipt_pkg::FAR_DOT;
      h       = two_p + sp;
    end
    if (h < 13'sd0) begin
      r.pos = '0;
    end else if (h > $signed({2'b00, lim})) begin
      r.pos = lim;
    end else begin
      r.pos = h[10:0];
    end
    return r;
  endfunction

  ipt_pkg::mem_t  first_x_r, second_x_r, first_y_r, second_y_r;
  ipt_pkg::mem_t  first_x_nxt, second_x_nxt, first_y_nxt, second_y_nxt;
  ipt_pkg::spc_t  spacing_x_r, spacing_y_r, spacing_x_nxt, spacing_y_nxt;
  ipt_pkg::half_t held_x_r, held_y_r, held_x_nxt, held_y_nxt;
  ipt_pkg::pos_t  pos_r, pos_nxt;
  logic           pos_valid_r;
  logic           accept;

  ipt_pkg::axis_res_t ax_x;
  ipt_pkg::axis_res_t ax_y;
  logic           dot0_seen;
  logic           dot1_seen;
  logic [10:0]    sum_x;
  logic [10:0]    sum_y;

  assign in_stall  = pos_valid_r && pos_stall;
  assign accept    = in_valid && !in_stall;
  assign pos_valid = pos_valid_r;
  assign pos       = pos_r;

  assign ax_x = track_axis(dot0_x, first_x_r, second_x_r, spacing_x_r, ipt_pkg::LIMIT_X);
  assign ax_y = track_axis(dot0_y, first_y_r, second_y_r, spacing_y_r, ipt_pkg::LIMIT_Y);

  assign dot0_seen = (dot0_x != '0) || (dot0_y != '0);
  assign dot1_seen = (dot1_x != '0) || (dot1_y != '0);
  assign sum_x     = {1'b0, dot0_x} + {1'b0, dot1_x};
  assign sum_y     = {1'b0, dot0_y} + {1'b0, dot1_y};

  // Next tracking state and position for the word at the input
  always_comb begin
    first_x_nxt   = first_x_r;
    second_x_nxt  = second_x_r;
    first_y_nxt   = first_y_r;
    second_y_nxt  = second_y_r;
    spacing_x_nxt = spacing_x_r;
    spacing_y_nxt = spacing_y_r;
    held_x_nxt    = held_x_r;
    held_y_nxt    = held_y_r;
    pos_nxt       = '0;
    if (!track_on) begin
      // tracking off: forget the dots and spacing, keep the held position, point at zero
      first_x_nxt   = '0;
      second_x_nxt  = '0;
      first_y_nxt   = '0;
      second_y_nxt  = '0;
      spacing_x_nxt = '0;
      spacing_y_nxt = '0;
    end else begin
      if (dot0_seen && !dot1_seen) begin
        first_x_nxt  = ax_x.first;
        second_x_nxt = ax_x.second;
        first_y_nxt  = ax_y.first;
        second_y_nxt = ax_y.second;
        held_x_nxt   = ax_x.pos;
        held_y_nxt   = ax_y.pos;
      end else begin
        if ((dot0_x != '0) && (dot1_x != '0)) begin
          spacing_x_nxt = $signed({1'b0, dot0_x}) - $signed({1'b0, dot1_x});
        end
        if ((dot0_y != '0) && (dot1_y != '0)) begin
          spacing_y_nxt = $signed({1'b0, dot0_y}) - $signed({1'b0, dot1_y});
        end
        if (dot0_seen) begin
          // floored midpoint, kept in half pixels
          held_x_nxt   = {sum_x[10:1], 1'b0};
          held_y_nxt   = {sum_y[10:1], 1'b0};
          first_x_nxt  = {1'b0, dot0_x};
          second_x_nxt = {1'b0, dot1_x};
          first_y_nxt  = {1'b0, dot0_y};
          second_y_nxt = {1'b0, dot1_y};
        end
      end
      pos_nxt.x = held_x_nxt;
      pos_nxt.y = held_y_nxt;
    end
  end

  // Tracking state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_x_r   <= '0;
      second_x_r  <= '0;
      first_y_r   <= '0;
      second_y_r  <= '0;
      spacing_x_r <= '0;
      spacing_y_r <= '0;
      held_x_r    <= '0;
      held_y_r    <= '0;
    end else if (accept) begin
      first_x_r   <= first_x_nxt;
      second_x_r  <= second_x_nxt;
      first_y_r   <= first_y_nxt;
      second_y_r  <= second_y_nxt;
      spacing_x_r <= spacing_x_nxt;
      spacing_y_r <= spacing_y_nxt;
      held_x_r    <= held_x_nxt;
      held_y_r    <= held_y_nxt;
    end
  end

  // Position register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_valid_r <= 1'b0;
    end else if (!in_stall) begin
      pos_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pos_r <= pos_nxt;
    end
  end

endmodule

// File: src/ipt_scale.sv
// Scaling pipeline: half-pixel position times screen size over a constant, truncated and saturated.
module ipt_scale (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           pos_valid,
  output logic           pos_stall,
  input  ipt_pkg::pos_t  pos,
  input  ipt_pkg::size_t screen_width,
  input  ipt_pkg::size_t screen_height,
  output logic           out_valid,
  input  logic           out_stall,
  output ipt_pkg::pix_t  out_x,
  output ipt_pkg::pix_t  out_y
);

  // Quotient estimate: never above the true quotient, at most one below
  function automatic ipt_pkg::quo_t quo_est(input ipt_pkg::num_t n, input ipt_pkg::recip_t k);
    logic [36:0] m;
    m = {14'b0, n} * {23'b0, k};
    return m[36:ipt_pkg::RECIP_SHIFT];
  endfunction

  // One correction step, then saturation
  function automatic ipt_pkg::pix_t quo_fix(
    input ipt_pkg::num_t n,
    input ipt_pkg::quo_t q0,
    input ipt_pkg::div_t d
  );
    logic [23:0] qd;
    logic [23:0] rem;
    logic [14:0] q;
    qd  = {10'b0, q0} * {14'b0, d};
    rem = {1'b0, n} - qd;
    q   = {1'b0, q0} + 15'(rem >= {14'b0, d});
    return (q > {2'b0, ipt_pkg::OUT_MAX}) ? ipt_pkg::OUT_MAX : q[12:0];
  endfunction

  logic           v1_r, v2_r, out_valid_r;
  logic           rdy1, rdy2, rdy3;
  ipt_pkg::prod_t prod_x_r, prod_y_r;
  ipt_pkg::num_t  num_x_r, num_y_r;
  ipt_pkg::quo_t  q0_x_r, q0_y_r;
  ipt_pkg::pix_t  out_x_r, out_y_r;

  // A stage loads when it is empty or the next one takes its word
  assign rdy3      = !out_valid_r || !out_stall;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign pos_stall = !rdy1;
  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= pos_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        out_valid_r <= v2_r;
      end
    end
  end

  // Product stage
  always_ff @(posedge clk) begin
    if (rdy1 && pos_valid) begin
      prod_x_r <= {13'b0, pos.x} * {11'b0, screen_width};
      prod_y_r <= {13'b0, pos.y} * {11'b0, screen_height};
    end
  end

  // Reciprocal stage, on the product halved
  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      num_x_r <= prod_x_r[23:1];
      num_y_r <= prod_y_r[23:1];
      q0_x_r  <= quo_est(prod_x_r[23:1], ipt_pkg::RECIP_X);
      q0_y_r  <= quo_est(prod_y_r[23:1], ipt_pkg::RECIP_Y);
    end
  end

  // Correction and output register
  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      out_x_r <= quo_fix(num_x_r, q0_x_r, ipt_pkg::DIV_X);
      out_y_r <= quo_fix(num_y_r, q0_y_r, ipt_pkg::DIV_Y);
    end
  end

endmodule

// File: src/ir_pointer_tracker.sv
// IR pointer tracker: two-dot tracking and screen scaling, top level.
// Throughput: one word per cycle while out_stall is low; four register stages (position,
// product, quotient estimate, output) each hold one word and advance independently.
// Reset: synchronous, active low; dot memory, spacing and held position clear
// to zero, screen size goes to 1024 x 768, all stages empty.
module ir_pointer_tracker (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [0:0]      cfg_index,
  input  logic [12:0]     cfg_wdata,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            in_track_on,
  input  ipt_pkg::coord_t in_dot0_x,
  input  ipt_pkg::coord_t in_dot0_y,
  input  ipt_pkg::coord_t in_dot1_x,
  input  ipt_pkg::coord_t in_dot1_y,
  output logic            out_valid,
  input  logic            out_stall,
  output ipt_pkg::pix_t   out_pointer_x,
  output ipt_pkg::pix_t   out_pointer_y
);

  ipt_pkg::size_t screen_width_r;
  ipt_pkg::size_t screen_height_r;
  logic           pos_valid;
  logic           pos_stall;
  ipt_pkg::pos_t  pos;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r  <= ipt_pkg::SCREEN_WIDTH_RST;
      screen_height_r <= ipt_pkg::SCREEN_HEIGHT_RST;
    end else if (cfg_we) begin
      case (ipt_pkg::cfg_idx_t'(cfg_index))
        ipt_pkg::CFG_SCREEN_WIDTH: begin
          screen_width_r <= cfg_wdata;
        end
        ipt_pkg::CFG_SCREEN_HEIGHT: begin
          screen_height_r <= cfg_wdata;
        end
        default: begin
        end
      endcase
    end
  end

  ipt_track u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .track_on  (in_track_on),
    .dot0_x    (in_dot0_x),
    .dot0_y    (in_dot0_y),
    .dot1_x    (in_dot1_x),
    .dot1_y    (in_dot1_y),
    .pos_valid (pos_valid),
    .pos_stall (pos_stall),
    .pos       (pos)
  );

  ipt_scale u_scale (
    .clk           (clk),
    .rst_n         (rst_n),
    .pos_valid     (pos_valid),
    .pos_stall     (pos_stall),
    .pos           (pos),
    .screen_width  (screen_width_r),
    .screen_height (screen_height_r),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_x         (out_pointer_x),
    .out_y         (out_pointer_y)
  );

endmodule

// File: tb/tb_ir_pointer_tracker.sv
// Self-checking testbench of the IR pointer tracker: directed frames, then random frames.
`timescale 1ns / 1ps

module tb_ir_pointer_tracker;

  // One camera frame as offered on the input channel
  typedef struct packed {
    logic            ir;
    ipt_pkg::coord_t x0;
    ipt_pkg::coord_t y0;
    ipt_pkg::coord_t x1;
    ipt_pkg::coord_t y1;
  } frame_t;

  // One pointer word as returned on the result channel
  typedef struct packed {
    ipt_pkg::pix_t x;
    ipt_pkg::pix_t y;
  } pointer_t;

  // Directed row: frame, and a typed-in pointer where it is obvious
  typedef struct packed {
    frame_t   f;
    logic     typed;
    pointer_t want;
  } row_t;

  localparam int N_ROWS        = 21;
  localparam int N_PHASES      = 6;
  localparam int FRAMES_PER_PH = 255;
  localparam int HOLD_CYCLES   = 200;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int PRINT_CAP     = 100;

  logic     clk           = 1'b0;
  logic     rst_n         = 1'b0;
  logic     cfg_we        = 1'b0;
  logic [0:0] cfg_index   = ipt_pkg::CFG_SCREEN_WIDTH;
  logic [12:0] cfg_wdata  = '0;
  logic     in_valid      = 1'b0;
  logic     in_stall;
  logic     in_track_on   = 1'b0;
  ipt_pkg::coord_t in_dot0_x = '0;
  ipt_pkg::coord_t in_dot0_y = '0;
  ipt_pkg::coord_t in_dot1_x = '0;
  ipt_pkg::coord_t in_dot1_y = '0;
  logic     out_valid;
  logic     out_stall     = 1'b0;
  ipt_pkg::pix_t out_pointer_x;
  ipt_pkg::pix_t out_pointer_y;

  // Typed-in expectation riding along with the offered frame
  logic     row_typed     = 1'b0;
  pointer_t row_want      = '0;

  // Handshake pacing
  int       send_idle_pct = 0;
  int       stall_pct     = 0;
  bit       pressure_go   = 1'b0;
  logic     hold_on       = 1'b0;

  int       mismatches    = 0;
  pointer_t pointer_q[$];

  // Tracker state and screen size as the block should hold them
  ipt_pkg::size_t width_cfg  = ipt_pkg::SCREEN_WIDTH_RST;
  ipt_pkg::size_t height_cfg = ipt_pkg::SCREEN_HEIGHT_RST;
  ipt_pkg::mem_t  mem_fx     = '0;
  ipt_pkg::mem_t  mem_sx     = '0;
  ipt_pkg::mem_t  mem_fy     = '0;
  ipt_pkg::mem_t  mem_sy     = '0;
  ipt_pkg::spc_t  spc_x      = '0;
  ipt_pkg::spc_t  spc_y      = '0;
  ipt_pkg::half_t held_x     = '0;
  ipt_pkg::half_t held_y     = '0;

  row_t dir_rows [N_ROWS] = '{
    '{'{1'b0, 10'd1023, 10'd767, 10'd1023, 10'd767}, 1'b1, '{13'd0,    13'd0}},
    '{'{1'b1, 10'd0,    10'd0,   10'd0,    10'd0},   1'b1, '{13'd0,    13'd0}},
    '{'{1'b1, 10'd1023, 10'd767, 10'd1023, 10'd767}, 1'b1, '{13'd1024, 13'd768}},
    '{'{1'b1, 10'd1,    10'd1,   10'd1,    10'd1},   1'b0, '{13'd0,    13'd0}},
    '{'{1'b1, 10'd500,  10'd400, 10'd0,    10'd0},   1'b0, '{13'd0,    13'd0}},
    '{'{1'b1, 10'd0,    10'd0,   10'd300,  10'd300}, 1'b0, '{13'd0,    13'd0}},
    '{'{1'b1, 10'd700,  10'd0,   10'd0,    10'd0},   1'b0, '{13'd0,    13'd0}},
    '{'{1'b1, 10'd100,  10'd0,   10'd900,  10'd500}, 1'b0, '{13'd0,    13'd0}},
    '{'{1'b0, 10'd0,    10'd0,   10'd0,    10'd0},   1'b1, '{13'd0,    13'd0}},
    '{'{1'b1, 10'd600,  10'd300, 10'd0,    10'd0},   1'b0, '{13'd0,    13'd0}},
    '{'{1'b1, 10'd1000, 10'd700, 10'd10,   10'd20},  1'b0, '{13'd0,    13'd0}},
    '{'{1'b1, 10'd999,  10'd699, 10'd0,    10'd0},   1'b0, '{13'd0,    13'd0}},
    '{'{1'b1, 10'd5,    10'd5,   10'd0,    10'd0},   1'b0, '{13'd0,    13'd0}},
    '{'{1'b1, 10'd10,   10'd20,  10'd1000, 10'd700}, 1'b0, '{13'd0,    13'd0}},
    '{'{1'b1, 10'd11,   10'd21,  10'd0,    10'd0},   1'b0, '{13'd0,    13'd0}},
    '{'{1'b1, 10'd1000, 10'd767, 10'd0,    10'd0},   1'b0, '{13'd0,    13'd0}},
    '{'{1'b1, 10'd1023, 10'd1023, 10'd1023, 10'd1023}, 1'b0, '{13'd0,  13'd0}},
    '{'{1'b1, 10'd0,    10'd767, 10'd0,    10'd1},   1'b0, '{13'd0,    13'd0}},
    '{'{1'b1, 10'd0,    10'd0,   10'd0,    10'd0},   1'b0, '{13'd0,    13'd0}},
    '{'{1'b1, 10'd512,  10'd0,   10'd512,  10'd0},   1'b0, '{13'd0,    13'd0}},
    '{'{1'b0, 10'd1023, 10'd1023, 10'd1023, 10'd1023}, 1'b1, '{13'd0,  13'd0}}
  };

  ir_pointer_tracker dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_track_on   (in_track_on),
    .in_dot0_x     (in_dot0_x),
    .in_dot0_y     (in_dot0_y),
    .in_dot1_x     (in_dot1_x),
    .in_dot1_y     (in_dot1_y),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pointer_x (out_pointer_x),
    .out_pointer_y (out_pointer_y)
  );

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Hard limit on run length
  initial begin
    #2_000_000;
    $display("ir_pointer_tracker regression: fail");
    $finish;
  end

  // Single-dot tracking on one axis: pick the surviving dot, shift by half spacing
  function automatic ipt_pkg::axis_res_t follow_axis(int p, ipt_pkg::mem_t first,
                                                     ipt_pkg::mem_t second,
                                                     ipt_pkg::spc_t spc, int limit);
    ipt_pkg::axis_res_t r;
    int        d_first;
    int        d_second;
    int        h;
    d_first  = int'(first) - p;
    d_second = int'(second) - p;
    if (d_first < 0) d_first = -d_first;
    if (d_second < 0) d_second = -d_second;
    r.first  = first;
    r.second = second;
    if (d_first < d_second) begin
      r.second = ipt_pkg::FAR_DOT;
      h = 2 * p - int'(spc);
    end else begin
      r.first = ipt_pkg::FAR_DOT;
      h = 2 * p + int'(spc);
    end
    if (h < 0) h = 0;
    if (h > limit) h = limit;
    r.pos = ipt_pkg::half_t'(h);
    return r;
  endfunction

  // Half-pixel position to screen pixels, truncated and saturated
  function automatic ipt_pkg::pix_t scale_pos(ipt_pkg::half_t pos, ipt_pkg::size_t size,
                                              int full);
    longint unsigned v;
    v = (longint'(pos) * longint'(size)) / longint'(2 * full);
    if (v > longint'(ipt_pkg::OUT_MAX)) return ipt_pkg::OUT_MAX;
    return ipt_pkg::pix_t'(v);
  endfunction

  // Pointer word for one accepted frame; advances the tracker state
  function automatic pointer_t predict_pointer(frame_t f);
    pointer_t  r;
    ipt_pkg::axis_res_t ax;
    ipt_pkg::axis_res_t ay;
    bit        seen0;
    bit        seen1;
    if (!f.ir) begin
      mem_fx = '0; mem_sx = '0; mem_fy = '0; mem_sy = '0;
      spc_x  = '0; spc_y  = '0;
      r = '0;
    end else begin
      seen0 = (f.x0 != 0) || (f.y0 != 0);
      seen1 = (f.x1 != 0) || (f.y1 != 0);
      if (!seen1 && seen0) begin
        ax = follow_axis(int'(f.x0), mem_fx, mem_sx, spc_x, int'(ipt_pkg::LIMIT_X));
        ay = follow_axis(int'(f.y0), mem_fy, mem_sy, spc_y, int'(ipt_pkg::LIMIT_Y));
        mem_fx = ax.first; mem_sx = ax.second; held_x = ax.pos;
        mem_fy = ay.first; mem_sy = ay.second; held_y = ay.pos;
      end else begin
        if (f.x0 != 0 && f.x1 != 0) spc_x = ipt_pkg::spc_t'(int'(f.x0) - int'(f.x1));
        if (f.y0 != 0 && f.y1 != 0) spc_y = ipt_pkg::spc_t'(int'(f.y0) - int'(f.y1));
        if (seen0) begin
          held_x = ipt_pkg::half_t'(((int'(f.x0) + int'(f.x1)) / 2) * 2);
          held_y = ipt_pkg::half_t'(((int'(f.y0) + int'(f.y1)) / 2) * 2);
          mem_fx = ipt_pkg::mem_t'(f.x0); mem_sx = ipt_pkg::mem_t'(f.x1);
          mem_fy = ipt_pkg::mem_t'(f.y0); mem_sy = ipt_pkg::mem_t'(f.y1);
        end
      end
      r.x = scale_pos(held_x, width_cfg, int'(ipt_pkg::DIV_X));
      r.y = scale_pos(held_y, height_cfg, int'(ipt_pkg::DIV_Y));
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < PRINT_CAP) $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Predict on accepted frames, check accepted pointer words
  always @(posedge clk) begin : scoreboard
    frame_t   cur;
    pointer_t want;
    if (rst_n && in_valid && !in_stall) begin
      cur.ir = in_track_on;
      cur.x0 = in_dot0_x;
      cur.y0 = in_dot0_y;
      cur.x1 = in_dot1_x;
      cur.y1 = in_dot1_y;
      want = predict_pointer(cur);
      if (row_typed) want = row_want;
      pointer_q.push_back(want);
    end
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pointer_q.size() == 0) begin
        report_mismatch($sformatf("pointer word %0d,%0d with no frame pending",
                                  out_pointer_x, out_pointer_y));
      end else begin
        want = pointer_q.pop_front();
        if (out_pointer_x !== want.x)
          report_mismatch($sformatf("pointer_x got %0d want %0d", out_pointer_x, want.x));
        if (out_pointer_y !== want.y)
          report_mismatch($sformatf("pointer_y got %0d want %0d", out_pointer_y, want.y));
      end
    end
  end

  // Result side: random stall, forced high during the hold-off
  always @(posedge clk) begin
    out_stall <= hold_on || ($urandom_range(0, 99) < stall_pct);
  end

  // Long hold-off of the result side, so the pipeline backs up to the input
  initial begin
    wait (pressure_go);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  // Offer one frame, with a random idle gap ahead of it
  task automatic send_frame(frame_t f, logic typed, pointer_t want);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid     <= 1'b1;
    in_track_on  <= f.ir;
    in_dot0_x    <= f.x0;
    in_dot0_y    <= f.y0;
    in_dot1_x    <= f.x1;
    in_dot1_y    <= f.y1;
    row_typed    <= typed;
    row_want     <= want;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop offering and wait until every pointer word is back, or the drain limit runs out
  task automatic drain();
    int n;
    n = 0;
    in_valid <= 1'b0;
    while (pointer_q.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic write_screen(ipt_pkg::size_t w, ipt_pkg::size_t h);
    cfg_we    <= 1'b1;
    cfg_index <= ipt_pkg::CFG_SCREEN_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= ipt_pkg::CFG_SCREEN_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we    <= 1'b0;
    width_cfg  = w;
    height_cfg = h;
    @(posedge clk);
  endtask

  // Coordinate with extra weight on not-seen and the top value
  function automatic ipt_pkg::coord_t pick_coord(int top);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return ipt_pkg::coord_t'(top);
    return ipt_pkg::coord_t'($urandom_range(1, top));
  endfunction

  // Mostly active frames with two or one dot; some blank, inactive or raw noise
  function automatic frame_t random_frame();
    frame_t f;
    int     kind;
    int     ytop;
    kind = $urandom_range(0, 99);
    ytop = ($urandom_range(0, 7) == 0) ? 1023 : 767;
    f.ir = 1'b1;
    f.x0 = pick_coord(1023);
    f.y0 = pick_coord(ytop);
    f.x1 = pick_coord(1023);
    f.y1 = pick_coord(ytop);
    if (kind < 45) begin
      // both dots as drawn
    end else if (kind < 80) begin
      f.x1 = '0;
      f.y1 = '0;
    end else if (kind < 90) begin
      f.x0 = '0;
      f.y0 = '0;
    end else if (kind < 95) begin
      f.ir = 1'b0;
    end else begin
      f.ir = 1'($urandom_range(0, 1));
      f.x0 = ipt_pkg::coord_t'($urandom_range(0, 1023));
      f.y0 = ipt_pkg::coord_t'($urandom_range(0, 1023));
      f.x1 = ipt_pkg::coord_t'($urandom_range(0, 1023));
      f.y1 = ipt_pkg::coord_t'($urandom_range(0, 1023));
    end
    return f;
  endfunction

  // Main sequence
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames at the reset screen size
    for (int i = 0; i < N_ROWS; i++) begin
      send_frame(dir_rows[i].f, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;  stall_pct = 0;
        end
        1: begin
          send_idle_pct = 50; stall_pct = 0;
          write_screen(13'd1, 13'd1);
        end
        2: begin
          send_idle_pct = 0;  stall_pct = 50;
          write_screen(13'd8191, 13'd8191);
          pressure_go = 1'b1;
        end
        3: begin
          send_idle_pct = 34; stall_pct = 34;
          write_screen(13'd4096, 13'd4096);
        end
        4: begin
          send_idle_pct = 50; stall_pct = 0;
          write_screen(13'd0, ipt_pkg::size_t'($urandom_range(1, 4096)));
        end
        default: begin
          send_idle_pct = 34; stall_pct = 34;
          write_screen(ipt_pkg::size_t'($urandom_range(1, 4096)),
                       ipt_pkg::size_t'($urandom_range(1, 4096)));
        end
      endcase
      for (int k = 0; k < FRAMES_PER_PH; k++) begin
        send_frame(random_frame(), 1'b0, '0);
      end
      drain();
    end

    if (pointer_q.size() != 0)
      report_mismatch($sformatf("%0d frames never answered", pointer_q.size()));
    if (mismatches == 0) begin
      $display("ir_pointer_tracker regression: pass");
    end else begin
      $display("ir_pointer_tracker regression: fail");
    end
    $finish;
  end

endmodule
